>>> hw/rtl/sample_ring_buffer_assert.svh
// Assertion macros for the checker file of the sample ring buffer.
// Each macro takes a label, the clock, the active-low reset, a condition and
// the property that must follow from it.
`ifndef SAMPLE_RING_BUFFER_ASSERT_SVH
`define SAMPLE_RING_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sample_ring_buffer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sample_ring_buffer: next-cycle check failed");

`endif

>>> hw/rtl/srb_pkg.sv
package srb_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_BURST_DEF = 64;

    localparam int SAMPLE_W = 32;
    localparam int REQ_W    = 3;
    localparam int COUNT_W  = 7;
    localparam int OFFSET_W = 10;
    localparam int FILL_W   = 10;
    localparam int STATUS_W = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH    = 3'd0,
        REQ_READ    = 3'd1,
        REQ_SCAN    = 3'd2,
        REQ_DISCARD = 3'd3,
        REQ_PEEK    = 3'd4,
        REQ_CLEAR   = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_OVERFLOW   = 2'd1,
        STAT_UNDERFLOW  = 2'd2,
        STAT_PEEK_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

>>> hw/rtl/sample_ring_buffer.sv
// Ring FIFO for 32-bit audio samples. The store holds DEPTH entries, of which
// DEPTH-1 are usable, addressed by a read and a write pointer that wrap at
// DEPTH (any DEPTH, not only powers of two). Each request transaction carries
// its kind in tuser: push, read (consumes), scan (does not consume), discard,
// peek at an offset from the oldest sample, or clear. Every request yields one
// result transaction, except a successful read or scan of N samples, which
// yields N results, oldest first, with tlast on the final one. Errors change
// nothing and return a single result whose tuser holds the status code.
// Timing: a request is taken in the idle state and executed in the execute
// state, and no new request is taken until it is done. The burst is paced by
// the sample memory, which delivers one word per cycle through its read
// register while the output is not stalled. While a result waits for the
// downstream side the block stalls. Clear only resets the pointers; no
// clearing pass runs, and the block is ready right after reset.
module sample_ring_buffer
    import srb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request side.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata fields, low bit up: sample_in[31:0], burst_count[38:32],
    // peek_offset[48:39], zero padding.
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser fields: req_type[2:0].
    input  logic [REQ_W-1:0]     i_s_axis_tuser,
    // Result side.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata fields, low bit up: sample_out[31:0], fill_level[41:32],
    // zero padding.
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser fields: status[1:0].
    output logic [STATUS_W-1:0]  o_m_axis_tuser,
    output logic                 o_m_axis_tlast
);

    localparam int PTR_W = $clog2(DEPTH);
    // Arithmetic width: wide enough for pointer sums and the 10-bit fields.
    localparam int CMP_W = ((PTR_W > OFFSET_W) ? PTR_W : OFFSET_W) + 1;
    localparam logic [CMP_W-1:0]   DEPTH_X     = CMP_W'(DEPTH);
    localparam logic [COUNT_W-1:0] MAX_BURST_C = COUNT_W'(MAX_BURST);

    // Wrap a pointer sum that is known to stay below twice the depth.
    function automatic logic [CMP_W-1:0] wrap_ptr(input logic [CMP_W-1:0] sum);
        return (sum >= DEPTH_X) ? (sum - DEPTH_X) : sum;
    endfunction

    // Control state.
    t_state               r_state, n_state;
    logic [PTR_W-1:0]     r_rp, n_rp;
    logic [PTR_W-1:0]     r_wp, n_wp;
    logic [COUNT_W-1:0]   r_idx, n_idx;

    // Latched request.
    t_req                 r_req;
    logic [SAMPLE_W-1:0]  r_sample_in;
    logic [COUNT_W-1:0]   r_count;
    logic [OFFSET_W-1:0]  r_offset;

    // Output register. The sample word itself is the memory read register.
    logic                 r_out_valid;
    logic                 r_out_rd;
    t_status              r_out_status;
    logic [FILL_W-1:0]    r_out_fill;
    logic                 r_out_last;
    logic [SAMPLE_W-1:0]  mem_rdata;

    logic                 in_accept;
    logic                 out_free;

    // Execute-stage results.
    logic                 ex_load;
    logic                 ex_done;
    logic                 res_rd;
    t_status              res_status;
    logic [FILL_W-1:0]    res_fill;
    logic                 res_last;
    logic                 mem_we;
    logic                 mem_re;
    logic [PTR_W-1:0]     mem_raddr;

    logic [CMP_W-1:0]     rp_x, wp_x, fill_x, count_x, off_x, idx_x;
    logic [CMP_W-1:0]     fill_after;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    // The output register can take a new result when empty or being drained.
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign rp_x    = CMP_W'(r_rp);
    assign wp_x    = CMP_W'(r_wp);
    assign fill_x  = (r_wp >= r_rp) ? (wp_x - rp_x) : (wp_x + DEPTH_X - rp_x);
    assign count_x = CMP_W'(r_count);
    assign off_x   = CMP_W'(r_offset);
    assign idx_x   = CMP_W'(r_idx);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (ex_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Execute logic: one result per cycle while the output register is free.
    always_comb begin
        ex_load    = 1'b0;
        ex_done    = 1'b0;
        res_rd     = 1'b0;
        res_status = STAT_OK;
        res_fill   = fill_x[FILL_W-1:0];
        res_last   = 1'b1;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = r_rp;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_idx      = r_idx;
        fill_after = fill_x;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_idx = '0;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    ex_load = 1'b1;
                    ex_done = 1'b1;
                    case (r_req)
                        REQ_PUSH: begin
                            if (fill_x >= DEPTH_X - CMP_W'(1)) begin
                                res_status = STAT_OVERFLOW;
                            end else begin
                                mem_we     = 1'b1;
                                n_wp       = PTR_W'(wrap_ptr(wp_x + CMP_W'(1)));
                                fill_after = fill_x + CMP_W'(1);
                                res_fill   = fill_after[FILL_W-1:0];
                            end
                        end
                        REQ_READ, REQ_SCAN: begin
                            if (count_x > fill_x || r_count > MAX_BURST_C) begin
                                res_status = STAT_UNDERFLOW;
                            end else if (r_count != '0) begin
                                // One stored sample per cycle while the output register is free, oldest first.
                                if (r_req == REQ_READ) begin
                                    fill_after = fill_x - count_x;
                                end
                                res_fill  = fill_after[FILL_W-1:0];
                                res_rd    = 1'b1;
                                mem_re    = 1'b1;
                                mem_raddr = PTR_W'(wrap_ptr(rp_x + idx_x));
                                res_last  = (idx_x + CMP_W'(1) == count_x);
                                n_idx     = r_idx + COUNT_W'(1);
                                ex_done   = res_last;
                                if (res_last && r_req == REQ_READ) begin
                                    n_rp = PTR_W'(wrap_ptr(rp_x + count_x));
                                end
                            end
                        end
                        REQ_DISCARD: begin
                            if (count_x > fill_x) begin
                                res_status = STAT_UNDERFLOW;
                            end else begin
                                n_rp       = PTR_W'(wrap_ptr(rp_x + count_x));
                                fill_after = fill_x - count_x;
                                res_fill   = fill_after[FILL_W-1:0];
                            end
                        end
                        REQ_PEEK: begin
                            if (off_x >= fill_x) begin
                                res_status = STAT_PEEK_RANGE;
                            end else begin
                                res_rd    = 1'b1;
                                mem_re    = 1'b1;
                                mem_raddr = PTR_W'(wrap_ptr(rp_x + off_x));
                            end
                        end
                        REQ_CLEAR: begin
                            // Stale store contents are unreachable once the
                            // pointers meet, so only the pointers are reset.
                            n_rp     = '0;
                            n_wp     = '0;
                            res_fill = '0;
                        end
                        default: begin
                            // Unused request codes leave everything alone.
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_idx   <= n_idx;
            if (ex_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req       <= t_req'(i_s_axis_tuser);
            r_sample_in <= i_s_axis_tdata[SAMPLE_W-1:0];
            r_count     <= i_s_axis_tdata[SAMPLE_W +: COUNT_W];
            r_offset    <= i_s_axis_tdata[SAMPLE_W+COUNT_W +: OFFSET_W];
        end
        if (ex_load) begin
            r_out_rd     <= res_rd;
            r_out_status <= res_status;
            r_out_fill   <= res_fill;
            r_out_last   <= res_last;
        end
    end

    srb_sample_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (r_sample_in),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        (M_TDATA_W - SAMPLE_W - FILL_W)'(0),
        r_out_fill,
        (r_out_rd ? mem_rdata : SAMPLE_W'(0))
    };
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

endmodule

>>> hw/rtl/srb_sample_mem.sv
module srb_sample_mem
    import srb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [SAMPLE_W-1:0]        i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [SAMPLE_W-1:0]        o_rdata
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    // Simple dual-port RAM; the read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/srb_port_chk.sv
`include "sample_ring_buffer_assert.svh"

module srb_port_chk
    import srb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 i_s_axis_tready,
    input logic                 i_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] i_m_axis_tdata,
    input logic [STATUS_W-1:0]  i_m_axis_tuser,
    input logic                 i_m_axis_tlast
);

    localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(DEPTH - 1);

    logic in_acc;
    logic out_err;

    assign in_acc  = i_s_axis_tvalid && i_s_axis_tready;
    assign out_err = i_m_axis_tvalid && (i_m_axis_tuser != STAT_OK);

    // One request is worked on at a time.
    `SRB_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, in_acc, !i_s_axis_tready)

    // A stalled result holds its payload.
    `SRB_ASSERT_NEXT(a_result_held, i_clk, i_rst_n,
        i_m_axis_tvalid && !i_m_axis_tready,
        i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))

    // Errors end their request at once and carry no sample.
    `SRB_ASSERT_NOW(a_error_single, i_clk, i_rst_n, out_err,
        i_m_axis_tlast && (i_m_axis_tdata[SAMPLE_W-1:0] == '0))

    // An overflow is only reported when the store is full.
    `SRB_ASSERT_NOW(a_overflow_full, i_clk, i_rst_n,
        i_m_axis_tvalid && (i_m_axis_tuser == STAT_OVERFLOW),
        i_m_axis_tdata[SAMPLE_W +: FILL_W] == FULL_LEVEL)

endmodule

bind sample_ring_buffer srb_port_chk #(
    .DEPTH (DEPTH)
) u_srb_port_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);
